### sv/ultrasonic_distance_keeper_assert.svh
// assertion macros shared by the checker of the distance keeper
// no dependencies; the includer supplies clock and reset names as arguments
`ifndef ULTRASONIC_DISTANCE_KEEPER_ASSERT_SVH
`define ULTRASONIC_DISTANCE_KEEPER_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define UDK_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("udk assertion failed");

// condition holds in the cycle after the trigger
`define UDK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("udk assertion failed");

`endif

### sv/udk_pkg.sv
// shared types and constants of the ultrasonic distance keeper
// no dependencies
package udk_pkg;

  localparam int ECHO_W  = 16;
  localparam int LIGHT_W = 8;
  localparam int DIST_W  = 14;
  localparam int SPEED_W = 5;
  localparam int RUN_W   = 2;
  localparam int TGT_W   = 8;
  localparam int TOL_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // count * 11 * 174 / 10000 as two constant multiplies
  localparam int PROD_W = 27;
  localparam logic [10:0] SCALE_MUL = 11'd1914;
  localparam int DIV_SHIFT = 41;
  localparam int RECIP_W   = 28;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 28'd219902326;

  localparam logic [DIST_W-1:0] FAR_MM  = 14'd500;
  localparam logic [DIST_W-1:0] MID_MM  = 14'd200;
  localparam logic [DIST_W-1:0] NEAR_MM = 14'd150;

  localparam logic [SPEED_W-1:0] SPEED_FAST = 5'd16;
  localparam logic [SPEED_W-1:0] SPEED_MID  = 5'd10;
  localparam logic [SPEED_W-1:0] SPEED_SLOW = 5'd4;
  localparam logic [SPEED_W-1:0] SPEED_STOP = 5'd0;

  localparam logic [RUN_W-1:0] RUN_LEN = 2'd3;

  localparam logic [TGT_W-1:0]   TARGET_RST = 8'd125;
  localparam logic [TOL_W-1:0]   TOL_RST    = 6'd5;
  localparam logic [LIGHT_W-1:0] THRESH_RST = 8'd130;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 2'd0,
    CFG_TOL    = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [TGT_W-1:0]   target_mm;
    logic [TOL_W-1:0]   tolerance_mm;
    logic [LIGHT_W-1:0] light_threshold;
  } cfg_regs_t;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
    logic s3_load;
    logic s4_load;
    logic out_load;
  } pipe_ctrl_t;

endpackage

### sv/udk_convert.sv
// echo count to millimetres: input register, scale multiply, reciprocal divide
// depends on udk_pkg
module udk_convert import udk_pkg::*; (
  input  logic               clk,
  input  pipe_ctrl_t         ctrl,
  input  logic [ECHO_W-1:0]  echo_count,
  input  logic [LIGHT_W-1:0] light_level,
  output logic [DIST_W-1:0]  fresh_mm,
  output logic [LIGHT_W-1:0] light3
);

  localparam int QPROD_W = PROD_W + RECIP_W;

  logic [ECHO_W-1:0]  echo1;
  logic [LIGHT_W-1:0] light1;
  logic [PROD_W-1:0]  prod2;
  logic [LIGHT_W-1:0] light2;
  logic [QPROD_W-1:0] qprod;

  // reciprocal is exact for every product below 2**27
  assign qprod = QPROD_W'(prod2) * QPROD_W'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (ctrl.s1_load) begin
      echo1  <= echo_count;
      light1 <= light_level;
    end
    if (ctrl.s2_load) begin
      prod2  <= PROD_W'(echo1) * PROD_W'(SCALE_MUL);
      light2 <= light1;
    end
    if (ctrl.s3_load) begin
      fresh_mm <= qprod[DIV_SHIFT +: DIST_W];
      light3   <= light2;
    end
  end

endmodule

### sv/udk_filter.sv
// distance window and rounded mean of the last WINDOW_LEN readings; the fresh reading until all are nonzero
// depends on udk_pkg
module udk_filter import udk_pkg::*; #(
  parameter int WINDOW_LEN = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  pipe_ctrl_t         ctrl,
  input  logic [DIST_W-1:0]  fresh_mm,
  input  logic [LIGHT_W-1:0] light3,
  output logic [DIST_W-1:0]  dist4,
  output logic [LIGHT_W-1:0] light4
);

  localparam int LOG_N   = $clog2(WINDOW_LEN);
  localparam int SUM_W   = DIST_W + LOG_N;
  localparam int SHIFT   = SUM_W + LOG_N;
  localparam int RCP_W   = SHIFT + 1;
  localparam longint RCP = ((64'd1 << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int MPROD_W = SUM_W + RCP_W;
  localparam int HALF    = WINDOW_LEN / 2;

  logic [DIST_W-1:0]  window      [WINDOW_LEN];
  logic [DIST_W-1:0]  window_next [WINDOW_LEN];
  logic [SUM_W-1:0]   sum;
  logic               all_set;
  logic [MPROD_W-1:0] mprod;
  logic [DIST_W-1:0]  dist_next;

  always_comb begin
    window_next[0] = fresh_mm;
    for (int i = 1; i < WINDOW_LEN; i++) begin
      window_next[i] = window[i-1];
    end
  end

  always_comb begin
    sum     = SUM_W'(HALF);
    all_set = 1'b1;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      sum = sum + SUM_W'(window_next[i]);
      if (window_next[i] == '0) begin
        all_set = 1'b0;
      end
    end
  end

  // divide by the window length through a ceiling reciprocal
  assign mprod     = MPROD_W'(sum) * MPROD_W'(RCP_W'(RCP));
  assign dist_next = all_set ? mprod[SHIFT +: DIST_W] : fresh_mm;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window[i] <= '0;
      end
    end else if (ctrl.s4_load) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.s4_load) begin
      dist4  <= dist_next;
      light4 <= light3;
    end
  end

endmodule

### sv/udk_decide.sv
// speed tiers, stop band, parking runs and light latch; state is the output register
// depends on udk_pkg
module udk_decide import udk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  pipe_ctrl_t         ctrl,
  input  cfg_regs_t          cfg,
  input  logic [DIST_W-1:0]  dist4,
  input  logic [LIGHT_W-1:0] light4,
  output logic [DIST_W-1:0]  distance_mm,
  output logic [SPEED_W-1:0] speed,
  output logic               forward,
  output logic               alarm,
  output logic               parked,
  output logic               motor_enable,
  output logic               timing_on
);

  logic [TGT_W:0]     band_hi;
  logic [TGT_W-1:0]   band_lo;
  logic               in_band;
  logic               above;
  logic               below;
  logic [RUN_W-1:0]   far_run;
  logic [RUN_W-1:0]   near_run;
  logic [SPEED_W-1:0] speed_next;
  logic               forward_next;
  logic               alarm_next;
  logic               parked_next;
  logic               enable_next;
  logic               timing_next;
  logic [RUN_W-1:0]   far_run_next;
  logic [RUN_W-1:0]   near_run_next;

  assign band_hi = {1'b0, cfg.target_mm} + (TGT_W+1)'(cfg.tolerance_mm);
  // low edge saturates at zero when tolerance exceeds target
  assign band_lo = (cfg.target_mm >= TGT_W'(cfg.tolerance_mm)) ?
                   cfg.target_mm - TGT_W'(cfg.tolerance_mm) : '0;
  assign above   = dist4 > DIST_W'(band_hi);
  assign below   = dist4 < DIST_W'(band_lo);
  assign in_band = !above && !below;

  always_comb begin
    speed_next    = speed;
    forward_next  = forward;
    alarm_next    = alarm;
    parked_next   = parked;
    enable_next   = motor_enable;
    timing_next   = timing_on;
    far_run_next  = far_run;
    near_run_next = near_run;

    if (dist4 > FAR_MM) begin
      speed_next = SPEED_FAST;
    end else if (dist4 > MID_MM) begin
      speed_next = SPEED_MID;
    end else if (dist4 > NEAR_MM) begin
      speed_next = SPEED_SLOW;
    end

    if (in_band) begin
      if (!parked) begin
        timing_next = 1'b0;
        parked_next = 1'b1;
      end
      speed_next    = SPEED_STOP;
      far_run_next  = '0;
      near_run_next = '0;
    end

    if (parked_next && above) begin
      far_run_next  = far_run_next + 1'b1;
      near_run_next = '0;
      if (far_run_next == RUN_LEN) begin
        forward_next = 1'b1;
        speed_next   = SPEED_SLOW;
        far_run_next = '0;
      end
    end

    // a below reading that does not finish a run leaves the alarm as it was
    if (parked_next && below) begin
      near_run_next = near_run_next + 1'b1;
      far_run_next  = '0;
      if (near_run_next == RUN_LEN) begin
        alarm_next    = 1'b1;
        forward_next  = 1'b0;
        speed_next    = SPEED_SLOW;
        near_run_next = '0;
      end
    end else begin
      alarm_next = 1'b0;
    end

    if (light4 > cfg.light_threshold) begin
      timing_next = 1'b1;
      enable_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed        <= SPEED_STOP;
      forward      <= 1'b1;
      alarm        <= 1'b0;
      parked       <= 1'b0;
      motor_enable <= 1'b0;
      timing_on    <= 1'b0;
      far_run      <= '0;
      near_run     <= '0;
    end else if (ctrl.out_load) begin
      speed        <= speed_next;
      forward      <= forward_next;
      alarm        <= alarm_next;
      parked       <= parked_next;
      motor_enable <= enable_next;
      timing_on    <= timing_next;
      far_run      <= far_run_next;
      near_run     <= near_run_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      distance_mm <= dist4;
    end
  end

endmodule

### sv/ultrasonic_distance_keeper.sv
// top level of the ultrasonic distance keeper: handshake, pipeline valids, config registers
// depends on udk_pkg, udk_convert, udk_filter, udk_decide
//
// Input channel: in_valid/in_stall with echo_count and light_level; one
// transaction per measurement. Output channel: out_valid/out_stall with one
// result transaction per input (distance_mm, speed, forward, alarm, parked,
// motor_enable, timing_on).
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Index 0 target_mm, 1 tolerance_mm, 2 light_threshold; other
// indexes are ignored. Write only while no transaction is in flight.
// Pipeline: input register, scale multiply, reciprocal divide, window mean,
// then the decision stage whose state registers are the result register.
// One item per cycle is taken when the output is not stalled. The decision
// feedback loop is a compare-and-select and sets that rate.
// When the receiver stalls, the result holds and the four stages in front of
// it keep filling; in_stall rises only once every stage holds an item.
// Reset (rst, synchronous) empties the pipeline, clears the window and state
// and loads the register defaults 125, 5 and 130.
module ultrasonic_distance_keeper import udk_pkg::*; #(
  parameter int WINDOW_LEN = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ECHO_W-1:0]     echo_count,
  input  logic [LIGHT_W-1:0]    light_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DIST_W-1:0]     distance_mm,
  output logic [SPEED_W-1:0]    speed,
  output logic                  forward,
  output logic                  alarm,
  output logic                  parked,
  output logic                  motor_enable,
  output logic                  timing_on,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pipe_ctrl_t         ctrl;
  cfg_regs_t          cfg;
  logic               v1, v2, v3, v4;
  logic               out_free, free4, free3, free2, free1;
  logic [DIST_W-1:0]  fresh_mm;
  logic [LIGHT_W-1:0] light3;
  logic [DIST_W-1:0]  dist4;
  logic [LIGHT_W-1:0] light4;

  assign out_free = !out_valid || !out_stall;
  assign free4    = !v4 || out_free;
  assign free3    = !v3 || free4;
  assign free2    = !v2 || free3;
  assign free1    = !v1 || free2;
  assign in_stall = !free1;

  assign ctrl.s1_load  = in_valid && free1;
  assign ctrl.s2_load  = v1 && free2;
  assign ctrl.s3_load  = v2 && free3;
  assign ctrl.s4_load  = v3 && free4;
  assign ctrl.out_load = v4 && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (free1) v1 <= in_valid;
      if (free2) v2 <= v1;
      if (free3) v3 <= v2;
      if (free4) v4 <= v3;
      if (out_free) out_valid <= v4;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_mm       <= TARGET_RST;
      cfg.tolerance_mm    <= TOL_RST;
      cfg.light_threshold <= THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TARGET: cfg.target_mm       <= TGT_W'(cfg_data);
        CFG_TOL:    cfg.tolerance_mm    <= TOL_W'(cfg_data);
        CFG_THRESH: cfg.light_threshold <= LIGHT_W'(cfg_data);
        default: ;
      endcase
    end
  end

  udk_convert u_convert (
    .clk         (clk),
    .ctrl        (ctrl),
    .echo_count  (echo_count),
    .light_level (light_level),
    .fresh_mm    (fresh_mm),
    .light3      (light3)
  );

  udk_filter #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_filter (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .fresh_mm (fresh_mm),
    .light3   (light3),
    .dist4    (dist4),
    .light4   (light4)
  );

  udk_decide u_decide (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .cfg          (cfg),
    .dist4        (dist4),
    .light4       (light4),
    .distance_mm  (distance_mm),
    .speed        (speed),
    .forward      (forward),
    .alarm        (alarm),
    .parked       (parked),
    .motor_enable (motor_enable),
    .timing_on    (timing_on)
  );

endmodule

### sv/udk_checker.sv
// port-level checks of the distance keeper and the bind that attaches them
// depends on udk_pkg and ultrasonic_distance_keeper_assert.svh
`include "ultrasonic_distance_keeper_assert.svh"

module udk_checker import udk_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [DIST_W-1:0]  distance_mm,
  input logic [SPEED_W-1:0] speed,
  input logic               forward,
  input logic               alarm,
  input logic               parked,
  input logic               motor_enable
);

  // a stalled result transaction keeps its payload
  `UDK_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && out_stall, out_valid && $stable(distance_mm) && $stable(speed))

  // parked and motor enable are latches that only reset clears
  `UDK_ASSERT_NEXT(a_parked_sticky, clk, rst, parked, parked)
  `UDK_ASSERT_NEXT(a_enable_sticky, clk, rst, motor_enable, motor_enable)

  // the alarm comes only from a reverse run of a parked car
  `UDK_ASSERT_NOW(a_alarm_reverse, clk, rst, alarm, parked && !forward)

  `UDK_ASSERT_NOW(a_speed_level, clk, rst, 1'b1, speed == SPEED_STOP || speed == SPEED_SLOW || speed == SPEED_MID || speed == SPEED_FAST)

endmodule

bind ultrasonic_distance_keeper udk_checker u_udk_checker (.*);

### tb/tb_ultrasonic_distance_keeper.sv
// testbench of ultrasonic_distance_keeper: a directed table, then random phases under
// several register settings, every result checked against a typed table row's expected value or an in-file predictor
// depends on udk_pkg and the ultrasonic_distance_keeper rtl
module tb_ultrasonic_distance_keeper;
  import udk_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int KEEP_DEPTH   = 4;
  localparam int PIPE_LATENCY = 4;
  localparam int IDLE_PCT     = 38;
  localparam int HOLD_CYCLES  = 80;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_ITEMS  = 100;
  localparam int RANDOM_PHASES = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [DIST_W-1:0]  dist_mm;
    logic [SPEED_W-1:0] speed;
    logic               fwd;
    logic               alarm;
    logic               parked;
    logic               enable;
    logic               timing;
  } keeper_result_t;

  typedef struct packed {
    logic [ECHO_W-1:0]  echo;
    logic [LIGHT_W-1:0] light;
    logic               typed;
    keeper_result_t     want;
  } stim_row_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] target;
    logic [CFG_DATA_W-1:0] tol;
    logic [CFG_DATA_W-1:0] thresh;
  } reg_setting_t;

  typedef enum int {BAND_IN, BAND_ABOVE, BAND_BELOW, SPEED_TIERS, ANY_ECHO, NO_ECHO}
    reading_kind_t;

  // echo 654 -> 125 mm, 684 -> 130, 685 -> 131, 627 -> 120, 622 -> 119
  localparam stim_row_t DIRECTED [25] = '{
    '{16'd0,     8'd0,   1'b1, '{14'd0,     SPEED_STOP, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{16'd65535, 8'd255, 1'b1, '{14'd12543, SPEED_FAST, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{16'd654,   8'd0,   1'b1, '{14'd125,   SPEED_STOP, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{16'd654,   8'd130, 1'b1, '{14'd125,   SPEED_STOP, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{16'd684,   8'd131, 1'b0, '0},
    '{16'd684,   8'd0,   1'b0, '0},
    '{16'd684,   8'd90,  1'b0, '0},
    '{16'd684,   8'd200, 1'b0, '0},
    '{16'd685,   8'd0,   1'b0, '0},
    '{16'd685,   8'd0,   1'b0, '0},
    '{16'd685,   8'd0,   1'b0, '0},
    '{16'd685,   8'd0,   1'b0, '0},
    '{16'd685,   8'd0,   1'b0, '0},
    '{16'd627,   8'd0,   1'b0, '0},
    '{16'd622,   8'd0,   1'b0, '0},
    '{16'd622,   8'd0,   1'b0, '0},
    '{16'd622,   8'd0,   1'b0, '0},
    '{16'd622,   8'd0,   1'b0, '0},
    '{16'd622,   8'd0,   1'b0, '0},
    '{16'd622,   8'd0,   1'b0, '0},
    '{16'd0,     8'd255, 1'b0, '0},
    '{16'd1,     8'd129, 1'b0, '0},
    '{16'd3000,  8'd0,   1'b0, '0},
    '{16'd1000,  8'd17,  1'b0, '0},
    '{16'd1500,  8'd240, 1'b0, '0}
  };

  // band below zero is the 10/63 row
  localparam reg_setting_t SETTING_PLAN [7] = '{
    '{8'd100, 8'd0,   8'd0},
    '{8'd150, 8'd50,  8'd255},
    '{8'd255, 8'hFF,  8'd128},
    '{8'd10,  8'd63,  8'd20},
    '{8'd0,   8'd0,   8'd200},
    '{8'd125, 8'd5,   8'd130},
    '{8'd140, 8'd3,   8'd127}
  };

  logic                  clk;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [ECHO_W-1:0]     echo_count  = '0;
  logic [LIGHT_W-1:0]    light_level = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [DIST_W-1:0]     distance_mm;
  logic [SPEED_W-1:0]    speed;
  logic                  forward;
  logic                  alarm;
  logic                  parked;
  logic                  motor_enable;
  logic                  timing_on;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  // predictor state
  logic [TGT_W-1:0]   model_target = TARGET_RST;
  logic [TOL_W-1:0]   model_tol    = TOL_RST;
  logic [LIGHT_W-1:0] model_thresh = THRESH_RST;
  logic [DIST_W-1:0]  recent_mm [KEEP_DEPTH] = '{default: '0};
  logic [SPEED_W-1:0] speed_now  = SPEED_STOP;
  logic               fwd_now    = 1'b1;
  logic               parked_now = 1'b0;
  logic               alarm_now  = 1'b0;
  logic               enable_now = 1'b0;
  logic               timing_now = 1'b0;
  logic [RUN_W-1:0]   far_count  = '0;
  logic [RUN_W-1:0]   near_count = '0;

  keeper_result_t pending_results [$];
  int             mismatches = 0;
  bit             gaps_on    = 1'b1;
  bit             hold_req   = 1'b0;

  ultrasonic_distance_keeper #(.WINDOW_LEN(KEEP_DEPTH)) i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * 500000);
    $display("ultrasonic_distance_keeper test failed");
    $finish;
  end

  function automatic int unsigned band_hi();
    return model_target + model_tol;
  endfunction

  function automatic int unsigned band_lo();
    return (model_target >= model_tol) ? model_target - model_tol : 0;
  endfunction

  function automatic keeper_result_t step_keeper(input logic [ECHO_W-1:0] echo,
                                                 input logic [LIGHT_W-1:0] light);
    int unsigned    fresh, sum, d, hi, lo;
    bit             full;
    keeper_result_t r;
    fresh = (32'(echo) * 11 * 174) / 10000;
    for (int i = KEEP_DEPTH - 1; i > 0; i--) recent_mm[i] = recent_mm[i-1];
    recent_mm[0] = fresh[DIST_W-1:0];
    full = 1'b1;
    sum  = 0;
    foreach (recent_mm[i]) begin
      if (recent_mm[i] == '0) full = 1'b0;
      sum += recent_mm[i];
    end
    // rounded mean only once the whole window holds nonzero readings
    d  = full ? (sum + KEEP_DEPTH / 2) / KEEP_DEPTH : recent_mm[0];
    hi = band_hi();
    lo = band_lo();

    if (d > FAR_MM) speed_now = SPEED_FAST;
    else if (d > MID_MM) speed_now = SPEED_MID;
    else if (d > NEAR_MM) speed_now = SPEED_SLOW;

    if (d >= lo && d <= hi) begin
      if (!parked_now) begin
        timing_now = 1'b0;
        parked_now = 1'b1;
      end
      speed_now  = SPEED_STOP;
      far_count  = '0;
      near_count = '0;
    end

    if (parked_now && d > hi) begin
      far_count  = far_count + 1'b1;
      near_count = '0;
      if (far_count == RUN_LEN) begin
        fwd_now   = 1'b1;
        speed_now = SPEED_SLOW;
        far_count = '0;
      end
    end

    // a below reading that does not end a run leaves the alarm as it was
    if (parked_now && d < lo) begin
      near_count = near_count + 1'b1;
      far_count  = '0;
      if (near_count == RUN_LEN) begin
        alarm_now  = 1'b1;
        fwd_now    = 1'b0;
        speed_now  = SPEED_SLOW;
        near_count = '0;
      end
    end else begin
      alarm_now = 1'b0;
    end

    if (light > model_thresh) begin
      timing_now = 1'b1;
      enable_now = 1'b1;
    end

    r.dist_mm = d[DIST_W-1:0];
    r.speed   = speed_now;
    r.fwd     = fwd_now;
    r.alarm   = alarm_now;
    r.parked  = parked_now;
    r.enable  = enable_now;
    r.timing  = timing_now;
    return r;
  endfunction

  // smallest echo count that converts to exactly mm
  function automatic logic [ECHO_W-1:0] echo_for_mm(input int unsigned mm);
    int unsigned e;
    e = (mm * 10000 + 1913) / 1914;
    return (e > 65535) ? '1 : e[ECHO_W-1:0];
  endfunction

  function automatic int unsigned mm_for(input reading_kind_t kind);
    int unsigned hi, lo;
    hi = band_hi();
    lo = band_lo();
    case (kind)
      BAND_IN:     return $urandom_range(hi, lo);
      BAND_ABOVE:  return hi + $urandom_range(1, 12);
      BAND_BELOW:  return (lo == 0) ? 0 : lo - $urandom_range(1, (lo < 12) ? lo : 12);
      SPEED_TIERS: return $urandom_range(140, 620);
      default:     return 0;
    endcase
  endfunction

  task automatic send_reading(input logic [ECHO_W-1:0] echo,
                              input logic [LIGHT_W-1:0] light,
                              input logic typed = 1'b0,
                              input keeper_result_t want = '0);
    keeper_result_t predicted;
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    echo_count  <= echo;
    light_level <= light;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = step_keeper(echo, light);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // leaves cfg_valid high so back to back writes need one assignment per edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TARGET: model_target = data[TGT_W-1:0];
      CFG_TOL:    model_tol    = data[TOL_W-1:0];
      CFG_THRESH: model_thresh = data[LIGHT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input reg_setting_t s);
    write_reg(CFG_TARGET, s.target);
    write_reg(CFG_TOL, s.tol);
    write_reg(CFG_SPARE, 8'($urandom));
    write_reg(CFG_THRESH, s.thresh);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // streaks of one kind of reading so the window mean and the run counters move
  task automatic run_readings(input int count);
    reading_kind_t      kind;
    int                 sent, streak, pick, lvl;
    logic [ECHO_W-1:0]  echo;
    logic [LIGHT_W-1:0] light;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) kind = BAND_IN;
      else if (pick < 50) kind = BAND_ABOVE;
      else if (pick < 70) kind = BAND_BELOW;
      else if (pick < 82) kind = SPEED_TIERS;
      else if (pick < 94) kind = ANY_ECHO;
      else kind = NO_ECHO;
      streak = $urandom_range(1, 6);
      repeat (streak) begin
        echo = (kind == ANY_ECHO) ? 16'($urandom) : echo_for_mm(mm_for(kind));
        if ($urandom_range(0, 1)) begin
          light = 8'($urandom);
        end else begin
          lvl = int'(model_thresh) + int'($urandom_range(0, 4)) - 2;
          light = (lvl < 0) ? 8'd0 : (lvl > 255) ? 8'd255 : 8'(lvl);
        end
        send_reading(echo, light);
        sent++;
      end
    end
  endtask

  initial begin
    int             hold_left;
    keeper_result_t got, want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = {distance_mm, speed, forward, alarm, parked, motor_enable, timing_on};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result transaction: dist %0d speed %0d", distance_mm, speed);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"mismatch: expected dist %0d speed %0d fwd %0b alarm %0b parked %0b",
                        " en %0b timing %0b, got dist %0d speed %0d fwd %0b alarm %0b",
                        " parked %0b en %0b timing %0b"},
                       want.dist_mm, want.speed, want.fwd, want.alarm, want.parked,
                       want.enable, want.timing, got.dist_mm, got.speed, got.fwd, got.alarm,
                       got.parked, got.enable, got.timing);
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= gaps_on && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin
    reg_setting_t s;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i])
      send_reading(DIRECTED[i].echo, DIRECTED[i].light, DIRECTED[i].typed, DIRECTED[i].want);
    run_readings(PHASE_ITEMS);
    settle();

    for (int p = 0; p < $size(SETTING_PLAN) + RANDOM_PHASES; p++) begin
      if (p < $size(SETTING_PLAN)) begin
        s = SETTING_PLAN[p];
      end else begin
        s.target = 8'($urandom);
        s.tol    = 8'($urandom);
        s.thresh = 8'($urandom);
      end
      apply_setting(s);
      // first phase runs with no gaps on either side
      gaps_on = (p != 0);
      if (p == 1) begin
        // receiver holds off while readings keep coming, then everything drains
        hold_req = 1'b1;
        run_readings(30);
        settle();
      end
      run_readings(PHASE_ITEMS);
      settle();
      gaps_on = 1'b1;
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ultrasonic_distance_keeper test passed");
    end else begin
      $display("ultrasonic_distance_keeper test failed");
    end
    $finish;
  end

endmodule

### ultrasonic_distance_keeper.f
+incdir+sv
sv/udk_pkg.sv
sv/udk_convert.sv
sv/udk_filter.sv
sv/udk_decide.sv
sv/ultrasonic_distance_keeper.sv
sv/udk_checker.sv
tb/tb_ultrasonic_distance_keeper.sv
